>>> sv/irt_pkg.sv
`default_nettype none

package irt_pkg;

	// Sizes of the text buffer and the fields.
	localparam int MAX_CHARS  = 64;
	localparam int DATA_W     = 64;
	localparam int DIG_W      = 6;
	localparam int CHAR_W     = 7;
	localparam int CNT_W      = $clog2(MAX_CHARS + 1);
	localparam int ADDR_W     = $clog2(MAX_CHARS);
	localparam int TOT_W      = 6;
	localparam int CAP_W      = 7;
	localparam int RADIX_W    = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_RADIX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ZPAD  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CAP   = 2'd3;

	// Register reset values and limits.
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [CAP_W-1:0]   CAP_RESET   = 7'd64;
	localparam logic [CAP_W-1:0]   CAP_MIN     = 7'd2;

	// Character codes.
	localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
	localparam logic [DIG_W-1:0]  DIGIT_TOP  = 6'd35;
	localparam logic [DIG_W-1:0]  DEC_DIGITS = 6'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SETUP,
		ST_SIGN,
		ST_PAD,
		ST_RD,
		ST_OUT
	} irt_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} irt_div_stat_t;

	// Digit value to its ASCII character.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d,
		input logic upper);
		logic [DIG_W-1:0] dc;
		dc = (d > DIGIT_TOP) ? DIGIT_TOP : d;
		if (dc < DEC_DIGITS) begin
			return CH_ZERO + CHAR_W'(dc);
		end
		return (upper ? CH_UPPER_A : CH_LOWER_A) + CHAR_W'(dc - DEC_DIGITS);
	endfunction

endpackage

`default_nettype wire

>>> sv/irt_ram.sv
`default_nettype none

module irt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> sv/irt_div.sv
`default_nettype none

module irt_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [irt_pkg::DATA_W-1:0]    dividend,
	input  wire logic [irt_pkg::RADIX_W-1:0]   divisor,
	output irt_pkg::irt_div_stat_t             stat,
	output logic      [irt_pkg::DATA_W-1:0]    quotient,
	output logic      [irt_pkg::DIG_W-1:0]     remainder
);

	import irt_pkg::*;

	localparam int STEP_W = $clog2(DATA_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);

	// Restoring division, one quotient bit per cycle. The dividend shifts out
	// at the top while quotient bits shift in at the bottom.
	logic [DATA_W-1:0] shreg_q;
	logic [DIG_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DIG_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, shreg_q[DATA_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= dividend;
			rem_q   <= '0;
		end else if (busy_q) begin
			shreg_q <= {shreg_q[DATA_W-2:0], fits};
			rem_q   <= fits ? DIG_W'(trial - {1'b0, divisor}) : DIG_W'(trial);
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = shreg_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

>>> sv/integer_radix_to_text.sv
// Integer to text conversion in a programmable radix.
//
// A request on the input channel (in_valid, in_stall) carries a 64-bit value
// and its kind (unsigned or signed). The block answers with a string of
// requests on the output channel (out_valid, out_stall), one ASCII character
// each, most significant first; last_char marks the final character and
// char_total then gives the length of the text. A capacity below two gives
// no characters at all.
// The configuration port writes radix, case, zero padding and capacity; it
// is to be written only while the block is idle; the block itself does not
// enforce this. Digits come from a bit-serial divider, one digit for each
// division, and each is stored in the digit memory; a value has at most 64
// digits. The sign and pad characters are emitted next, then the digits,
// each read back from the registered digit memory before it is emitted.
// One request is converted at a time; the next one is taken once the final
// character sits in the output register, even while that character is still
// stalled. Reset returns the registers to radix ten, lower case, no padding
// and a capacity of 64, and empties the output register. A stall on the
// output holds the character in place and pauses the emission.

`default_nettype none

module integer_radix_to_text (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             kind,
	input  wire logic [irt_pkg::DATA_W-1:0]       number_bits,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [irt_pkg::CHAR_W-1:0]       out_char,
	output logic                                  last_char,
	output logic      [irt_pkg::TOT_W-1:0]        char_total,
	input  wire logic                             cfg_we,
	input  wire logic [irt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [irt_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import irt_pkg::*;

	// Configuration registers.
	logic [RADIX_W-1:0] radix_q;
	logic               upper_case_q;
	logic               zero_pad_q;
	logic [CAP_W-1:0]   field_capacity_q;

	// Control state.
	irt_state_t       state_q, state_d;
	logic             neg_q;
	logic [CNT_W-1:0] digit_count_q;
	logic [CNT_W-1:0] pad_q;
	logic [CNT_W-1:0] idx_q;
	logic [TOT_W-1:0] left_q;
	logic [TOT_W-1:0] total_q;
	logic             out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic             last_char_q;
	logic [TOT_W-1:0] char_total_q;

	// Strobes from the sequencer.
	logic              accept;
	logic              go;
	logic              div_start;
	logic              dig_wr;
	logic              emit;
	logic [CHAR_W-1:0] emit_char;
	logic              slot_free;

	// Effective settings: the radix clamped into its legal range, the capacity limited to the buffer size.
	logic [RADIX_W-1:0] base_eff;
	logic [CAP_W-1:0]   cap_eff;
	logic               in_neg;
	logic [DATA_W-1:0]  magnitude;

	// Length arithmetic, used in the setup state.
	logic [CNT_W-1:0] avail;
	logic [CNT_W-1:0] kept;
	logic [CNT_W-1:0] pad;
	logic [CNT_W-1:0] total;

	// Divider and digit memory.
	irt_div_stat_t     div_stat;
	logic [DATA_W-1:0] div_quo;
	logic [DIG_W-1:0]  div_rem;
	logic [DATA_W-1:0] dividend;
	logic              div_stop;
	logic [DIG_W-1:0]  dig_rdata;
	logic [ADDR_W-1:0] dig_raddr;

	assign base_eff = (radix_q < RADIX_MIN) ? RADIX_MIN :
		(radix_q > RADIX_MAX) ? RADIX_MAX : radix_q;
	assign cap_eff  = (field_capacity_q > CAP_W'(MAX_CHARS)) ? CAP_W'(MAX_CHARS) :
		field_capacity_q;

	assign in_neg    = kind & number_bits[DATA_W-1];
	assign magnitude = in_neg ? (DATA_W'(0) - number_bits) : number_bits;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid & ~in_stall;
	assign go        = accept & (cap_eff >= CAP_MIN);
	assign slot_free = ~out_valid_q | ~out_stall;

	// The first division takes the magnitude; later ones continue on the
	// quotient that the divider still holds.
	assign dividend = (state_q == ST_IDLE) ? magnitude : div_quo;
	assign dig_wr   = (state_q == ST_DIV) & div_stat.done;
	assign div_stop = (div_quo == '0) ||
		(digit_count_q + CNT_W'(1) == CNT_W'(MAX_CHARS));

	assign avail = CNT_W'(cap_eff) - CNT_W'(1) - CNT_W'(neg_q);
	assign kept  = (digit_count_q < avail) ? digit_count_q : avail;
	assign pad   = zero_pad_q ? (avail - kept) : '0;
	assign total = CNT_W'(neg_q) + pad + kept;

	// Digits are read back highest first.
	assign dig_raddr = ADDR_W'(idx_q - CNT_W'(1));

	irt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (dividend),
		.divisor   (base_eff),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	irt_ram #(
		.WIDTH (DIG_W),
		.DEPTH (MAX_CHARS)
	) u_digits (
		.clk   (clk),
		.we    (dig_wr),
		.waddr (digit_count_q[ADDR_W-1:0]),
		.wdata (div_rem),
		.raddr (dig_raddr),
		.rdata (dig_rdata)
	);

	// Sequencer: next state and strobes.
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		emit      = 1'b0;
		emit_char = CH_ZERO;
		unique case (state_q)
			ST_IDLE: begin
				if (go) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					if (div_stop) begin
						state_d = ST_SETUP;
					end else begin
						div_start = 1'b1;
					end
				end
			end
			ST_SETUP: begin
				if (neg_q) begin
					state_d = ST_SIGN;
				end else if (pad != '0) begin
					state_d = ST_PAD;
				end else if (kept != '0) begin
					state_d = ST_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SIGN: begin
				emit_char = CH_MINUS;
				if (slot_free) begin
					emit = 1'b1;
					if (pad_q != '0) begin
						state_d = ST_PAD;
					end else if (idx_q != '0) begin
						state_d = ST_RD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_PAD: begin
				emit_char = CH_ZERO;
				if (slot_free) begin
					emit = 1'b1;
					if (pad_q == CNT_W'(1)) begin
						state_d = (idx_q != '0) ? ST_RD : ST_IDLE;
					end
				end
			end
			ST_RD: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				emit_char = digit_char(dig_rdata, upper_case_q);
				if (slot_free) begin
					emit    = 1'b1;
					state_d = (idx_q == CNT_W'(1)) ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q          <= RADIX_RESET;
			upper_case_q     <= 1'b0;
			zero_pad_q       <= 1'b0;
			field_capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RADIX: radix_q          <= cfg_data[RADIX_W-1:0];
				CFG_UPPER: upper_case_q     <= cfg_data[0];
				CFG_ZPAD:  zero_pad_q       <= cfg_data[0];
				CFG_CAP:   field_capacity_q <= cfg_data[CAP_W-1:0];
				default:   ;
			endcase
		end
	end

	// Digit count, emission counters and the sign of the current request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q         <= 1'b0;
			digit_count_q <= '0;
			pad_q         <= '0;
			idx_q         <= '0;
			left_q        <= '0;
			total_q       <= '0;
		end else begin
			if (go) begin
				neg_q         <= in_neg;
				digit_count_q <= '0;
			end else if (dig_wr) begin
				digit_count_q <= digit_count_q + CNT_W'(1);
			end
			if (state_q == ST_SETUP) begin
				pad_q   <= pad;
				idx_q   <= kept;
				left_q  <= TOT_W'(total);
				total_q <= TOT_W'(total);
			end else if (emit) begin
				left_q <= left_q - TOT_W'(1);
				if (state_q == ST_PAD) begin
					pad_q <= pad_q - CNT_W'(1);
				end
				if (state_q == ST_OUT) begin
					idx_q <= idx_q - CNT_W'(1);
				end
			end
		end
	end

	// Output register: it frees as soon as the receiver takes the character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q   <= emit_char;
			last_char_q  <= (left_q == TOT_W'(1));
			char_total_q <= (left_q == TOT_W'(1)) ? total_q : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign last_char  = last_char_q;
	assign char_total = char_total_q;

	// The divider only runs while a conversion is in progress.
	a_div_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == ST_DIV)
		else $error("divider busy outside conversion");

	// A request with a usable capacity starts a conversion.
	a_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> in_stall)
		else $error("accepted request did not start a conversion");

	// The final character carries a nonzero length, every other one zero.
	a_total_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_char |-> char_total != '0)
		else $error("final character without length");

	a_total_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_char |-> char_total == '0)
		else $error("length shown before the final character");

	// The digit count never runs past the memory.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		digit_count_q <= CNT_W'(MAX_CHARS))
		else $error("digit count beyond the digit memory");

endmodule

`default_nettype wire
